[hw/rtl/vpz_pkg.sv]
// Shared types, codes and constants of the viewport pan and zoom controller.
package vpz_pkg;

	// Field widths of the stream items.
	localparam int CMD_W    = 3;
	localparam int KEY_W    = 3;
	localparam int PTR_W    = 12;
	localparam int DT_W     = 10;
	localparam int POS_W    = 14;
	localparam int VEL_W    = 7;
	localparam int ZOOM_W   = 8;
	localparam int MARGIN_W = 10;
	localparam int SPEED_W  = 6;
	localparam int BAND_W   = 10;

	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 40;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 10;

	// Divide by ten as a multiply by a rounded-up reciprocal and a shift.
	// The product stays below 2^17, where this is exact for floor division.
	localparam int          RECIP_SHIFT = 19;
	localparam logic [15:0] RECIP_TEN   = 16'd52429;
	localparam int          DT_SC_W     = DT_W + 16;
	localparam int          PROD_W      = DT_SC_W + VEL_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 3'd0,
		CMD_PRESS   = 3'd1,
		CMD_RELEASE = 3'd2,
		CMD_POINTER = 3'd3,
		CMD_WHEEL   = 3'd4,
		CMD_RESIZE  = 3'd5
	} cmd_t;

	typedef enum logic [KEY_W-1:0] {
		KEY_UP    = 3'd0,
		KEY_LEFT  = 3'd1,
		KEY_DOWN  = 3'd2,
		KEY_RIGHT = 3'd3
	} key_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EDGE_MARGIN  = 3'd0,
		REG_KEY_SPEED    = 3'd1,
		REG_PTR_SPEED    = 3'd2,
		REG_EDGE_BAND    = 3'd3,
		REG_ZOOM_STEP    = 3'd4,
		REG_ZOOM_FLOOR   = 3'd5,
		REG_ZOOM_CEILING = 3'd6
	} reg_idx_t;

	localparam logic [MARGIN_W-1:0] EDGE_MARGIN_RST  = 10'd100;
	localparam logic [SPEED_W-1:0]  KEY_SPEED_RST    = 6'd4;
	localparam logic [SPEED_W-1:0]  PTR_SPEED_RST    = 6'd4;
	localparam logic [BAND_W-1:0]   EDGE_BAND_RST    = 10'd20;
	localparam logic [ZOOM_W-1:0]   ZOOM_STEP_RST    = 8'd4;
	localparam logic [ZOOM_W-1:0]   ZOOM_FLOOR_RST   = 8'd0;
	localparam logic [ZOOM_W-1:0]   ZOOM_CEILING_RST = 8'd100;

endpackage

[hw/rtl/viewport_pan_zoom_controller.sv]
// Viewport pan and zoom controller: event decode, camera state and result stream.

// One event beat is taken every cycle when the result side keeps up. An event
// is captured in an input register and its update is applied to the camera
// state when that register advances; the camera registers themselves are the
// result. A result that is not taken stalls the state update and, through it,
// the input side. A tick scales each axis velocity by elapsed time with one
// narrow multiplier per axis, divides by ten through a precomputed reciprocal,
// adds and clamps; this path from the input register to the camera registers
// sets the clock rate.
// Configuration writes are always accepted and must only arrive while idle.
module viewport_pan_zoom_controller #(
	parameter int COORD_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// key_code[2:0], pointer_x[14:3], pointer_y[26:15], wheel_up[27],
	// elapsed_time[37:28], new_width[49:38], new_height[61:50], zeros above
	input  logic [vpz_pkg::S_TDATA_W-1:0]   s_tdata,
	// cmd[2:0]
	input  logic [vpz_pkg::CMD_W-1:0]       s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// cam_x[13:0], cam_y[27:14], zoom_level[35:28], moved[36], zeros above
	output logic [vpz_pkg::M_TDATA_W-1:0]   m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [vpz_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vpz_pkg::CFG_DAT_W-1:0]   cfg_data
);

	localparam int CoordW = (COORD_BITS < vpz_pkg::PTR_W) ? COORD_BITS : vpz_pkg::PTR_W;
	localparam int PW     = vpz_pkg::POS_W;
	localparam int WW     = PW + 2;

	// Configuration registers.
	logic [vpz_pkg::MARGIN_W-1:0] edge_margin_q;
	logic [vpz_pkg::SPEED_W-1:0]  key_speed_q;
	logic [vpz_pkg::SPEED_W-1:0]  ptr_speed_q;
	logic [vpz_pkg::BAND_W-1:0]   edge_band_q;
	logic [vpz_pkg::ZOOM_W-1:0]   zoom_step_q;
	logic [vpz_pkg::ZOOM_W-1:0]   zoom_floor_q;
	logic [vpz_pkg::ZOOM_W-1:0]   zoom_ceiling_q;

	// Input register.
	logic                          valid_s1;
	vpz_pkg::cmd_t                 cmd_s1;
	logic [vpz_pkg::KEY_W-1:0]     key_s1;
	logic [CoordW-1:0]             ptr_x_s1;
	logic [CoordW-1:0]             ptr_y_s1;
	logic                          wheel_up_s1;
	logic [vpz_pkg::DT_SC_W-1:0]   dt_sc_s1;
	logic [CoordW-1:0]             new_w_s1;
	logic [CoordW-1:0]             new_h_s1;

	// Camera state, which is also the result register.
	logic signed [vpz_pkg::VEL_W-1:0] key_vel_x_q, key_vel_y_q;
	logic signed [vpz_pkg::VEL_W-1:0] edge_vel_x_q, edge_vel_y_q;
	logic signed [PW-1:0]             pos_x_q, pos_y_q;
	logic [vpz_pkg::ZOOM_W-1:0]       zoom_q;
	logic [CoordW-1:0]                view_w_q, view_h_q;
	logic                             changed_q;
	logic                             out_valid_q;

	logic                             advance;
	logic                             in_fire;
	logic [vpz_pkg::DT_SC_W-1:0]      dt_sc_in;

	logic signed [vpz_pkg::VEL_W-1:0] key_vel_x_d, key_vel_y_d;
	logic signed [vpz_pkg::VEL_W-1:0] edge_vel_x_d, edge_vel_y_d;
	logic signed [PW-1:0]             pos_x_d, pos_y_d;
	logic [vpz_pkg::ZOOM_W-1:0]       zoom_d;
	logic [CoordW-1:0]                view_w_d, view_h_d;
	logic                             changed_d;

	logic signed [vpz_pkg::VEL_W-1:0] key_pos_vel, key_neg_vel;
	logic signed [vpz_pkg::VEL_W-1:0] ptr_pos_vel, ptr_neg_vel;
	logic                             any_vel;
	logic signed [PW-1:0]             move_x, move_y;
	logic [vpz_pkg::ZOOM_W:0]         zoom_up;
	logic signed [vpz_pkg::ZOOM_W+1:0] zoom_dn;

	// Signed sum of two velocities, scaled by elapsed time over ten, clamped
	// to the window extended by the margin on both sides.
	function automatic logic signed [PW-1:0] move_axis(
		input logic signed [PW-1:0]               pos,
		input logic signed [vpz_pkg::VEL_W-1:0]   va,
		input logic signed [vpz_pkg::VEL_W-1:0]   vb,
		input logic [vpz_pkg::DT_SC_W-1:0]        dt_sc,
		input logic [CoordW-1:0]                  size,
		input logic [vpz_pkg::MARGIN_W-1:0]       margin
	);
		logic signed [vpz_pkg::VEL_W:0]   vsum;
		logic [vpz_pkg::VEL_W:0]          vneg;
		logic [vpz_pkg::VEL_W-1:0]        mag;
		logic [vpz_pkg::PROD_W-1:0]       prod;
		logic [PW-1:0]                    quo;
		logic signed [WW-1:0]             delta;
		logic signed [WW-1:0]             np;
		logic signed [WW-1:0]             lo;
		logic signed [WW-1:0]             hi;
		logic signed [PW-1:0]             res;
		vsum  = {va[vpz_pkg::VEL_W-1], va} + {vb[vpz_pkg::VEL_W-1], vb};
		vneg  = (vpz_pkg::VEL_W+1)'(-vsum);
		mag   = vsum[vpz_pkg::VEL_W] ? vneg[vpz_pkg::VEL_W-1:0] : vsum[vpz_pkg::VEL_W-1:0];
		prod  = vpz_pkg::PROD_W'(mag) * vpz_pkg::PROD_W'(dt_sc);
		quo   = prod[vpz_pkg::RECIP_SHIFT +: PW];
		delta = vsum[vpz_pkg::VEL_W] ? WW'(-$signed({2'b00, quo})) : $signed({2'b00, quo});
		np    = {{(WW-PW){pos[PW-1]}}, pos} + delta;
		lo    = WW'(-$signed({{(WW-vpz_pkg::MARGIN_W){1'b0}}, margin}));
		hi    = $signed({{(WW-CoordW){1'b0}}, size})
		      + $signed({{(WW-vpz_pkg::MARGIN_W){1'b0}}, margin});
		if (np < lo) begin
			res = lo[PW-1:0];
		end else if (np > hi) begin
			res = hi[PW-1:0];
		end else begin
			res = np[PW-1:0];
		end
		return res;
	endfunction

	// Pointer band velocity for one axis.
	function automatic logic signed [vpz_pkg::VEL_W-1:0] band_vel(
		input logic [CoordW-1:0]               p,
		input logic [CoordW-1:0]               size,
		input logic [vpz_pkg::BAND_W-1:0]      band,
		input logic signed [vpz_pkg::VEL_W-1:0] pos_vel,
		input logic signed [vpz_pkg::VEL_W-1:0] neg_vel
	);
		logic signed [PW-1:0]             pe;
		logic signed [PW-1:0]             upper;
		logic signed [vpz_pkg::VEL_W-1:0] v;
		pe    = $signed({{(PW-CoordW){1'b0}}, p});
		upper = $signed({{(PW-CoordW){1'b0}}, size})
		      - $signed({{(PW-vpz_pkg::BAND_W){1'b0}}, band});
		if (pe < $signed({{(PW-vpz_pkg::BAND_W){1'b0}}, band})) begin
			v = neg_vel;
		end else if (pe > upper) begin
			v = pos_vel;
		end else begin
			v = '0;
		end
		return v;
	endfunction

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign in_fire   = s_tvalid && s_tready;

	// Elapsed time is scaled by the reciprocal of ten before it is registered.
	assign dt_sc_in = vpz_pkg::DT_SC_W'(s_tdata[37:28]) * vpz_pkg::DT_SC_W'(vpz_pkg::RECIP_TEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_margin_q  <= vpz_pkg::EDGE_MARGIN_RST;
			key_speed_q    <= vpz_pkg::KEY_SPEED_RST;
			ptr_speed_q    <= vpz_pkg::PTR_SPEED_RST;
			edge_band_q    <= vpz_pkg::EDGE_BAND_RST;
			zoom_step_q    <= vpz_pkg::ZOOM_STEP_RST;
			zoom_floor_q   <= vpz_pkg::ZOOM_FLOOR_RST;
			zoom_ceiling_q <= vpz_pkg::ZOOM_CEILING_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vpz_pkg::REG_EDGE_MARGIN:  edge_margin_q  <= cfg_data;
				vpz_pkg::REG_KEY_SPEED:    key_speed_q    <= cfg_data[vpz_pkg::SPEED_W-1:0];
				vpz_pkg::REG_PTR_SPEED:    ptr_speed_q    <= cfg_data[vpz_pkg::SPEED_W-1:0];
				vpz_pkg::REG_EDGE_BAND:    edge_band_q    <= cfg_data;
				vpz_pkg::REG_ZOOM_STEP:    zoom_step_q    <= cfg_data[vpz_pkg::ZOOM_W-1:0];
				vpz_pkg::REG_ZOOM_FLOOR:   zoom_floor_q   <= cfg_data[vpz_pkg::ZOOM_W-1:0];
				vpz_pkg::REG_ZOOM_CEILING: zoom_ceiling_q <= cfg_data[vpz_pkg::ZOOM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1      <= vpz_pkg::cmd_t'(s_tuser);
			key_s1      <= s_tdata[2:0];
			ptr_x_s1    <= s_tdata[3 +: CoordW];
			ptr_y_s1    <= s_tdata[15 +: CoordW];
			wheel_up_s1 <= s_tdata[27];
			dt_sc_s1    <= dt_sc_in;
			new_w_s1    <= s_tdata[38 +: CoordW];
			new_h_s1    <= s_tdata[50 +: CoordW];
		end
	end

	assign key_pos_vel = $signed({1'b0, key_speed_q});
	assign key_neg_vel = vpz_pkg::VEL_W'(-$signed({1'b0, key_speed_q}));
	assign ptr_pos_vel = $signed({1'b0, ptr_speed_q});
	assign ptr_neg_vel = vpz_pkg::VEL_W'(-$signed({1'b0, ptr_speed_q}));
	assign any_vel     = (key_vel_x_q != '0) || (edge_vel_x_q != '0)
	                  || (key_vel_y_q != '0) || (edge_vel_y_q != '0);
	assign move_x = move_axis(pos_x_q, key_vel_x_q, edge_vel_x_q, dt_sc_s1, view_w_q,
		edge_margin_q);
	assign move_y = move_axis(pos_y_q, key_vel_y_q, edge_vel_y_q, dt_sc_s1, view_h_q,
		edge_margin_q);
	assign zoom_up = {1'b0, zoom_q} + {1'b0, zoom_step_q};
	assign zoom_dn = $signed({2'b00, zoom_q}) - $signed({2'b00, zoom_step_q});

	always_comb begin
		key_vel_x_d  = key_vel_x_q;
		key_vel_y_d  = key_vel_y_q;
		edge_vel_x_d = edge_vel_x_q;
		edge_vel_y_d = edge_vel_y_q;
		pos_x_d      = pos_x_q;
		pos_y_d      = pos_y_q;
		zoom_d       = zoom_q;
		view_w_d     = view_w_q;
		view_h_d     = view_h_q;
		changed_d    = changed_q;
		unique case (cmd_s1)
			vpz_pkg::CMD_TICK: begin
				changed_d = any_vel;
				if (any_vel) begin
					pos_x_d = move_x;
					pos_y_d = move_y;
				end
			end
			vpz_pkg::CMD_PRESS: begin
				unique case (key_s1)
					vpz_pkg::KEY_UP:    key_vel_y_d = key_neg_vel;
					vpz_pkg::KEY_LEFT:  key_vel_x_d = key_neg_vel;
					vpz_pkg::KEY_DOWN:  key_vel_y_d = key_pos_vel;
					vpz_pkg::KEY_RIGHT: key_vel_x_d = key_pos_vel;
					default: ;
				endcase
			end
			vpz_pkg::CMD_RELEASE: begin
				unique case (key_s1) inside
					vpz_pkg::KEY_UP, vpz_pkg::KEY_DOWN:     key_vel_y_d = '0;
					vpz_pkg::KEY_LEFT, vpz_pkg::KEY_RIGHT:  key_vel_x_d = '0;
					default: ;
				endcase
			end
			vpz_pkg::CMD_POINTER: begin
				edge_vel_x_d = band_vel(ptr_x_s1, view_w_q, edge_band_q, ptr_pos_vel,
					ptr_neg_vel);
				edge_vel_y_d = band_vel(ptr_y_s1, view_h_q, edge_band_q, ptr_pos_vel,
					ptr_neg_vel);
			end
			vpz_pkg::CMD_WHEEL: begin
				if (wheel_up_s1) begin
					// Each direction saturates only at its own bound.
					if (zoom_up > {1'b0, zoom_ceiling_q}) begin
						zoom_d = zoom_ceiling_q;
					end else begin
						zoom_d = zoom_up[vpz_pkg::ZOOM_W-1:0];
					end
				end else begin
					if (zoom_dn < $signed({2'b00, zoom_floor_q})) begin
						zoom_d = zoom_floor_q;
					end else begin
						zoom_d = zoom_dn[vpz_pkg::ZOOM_W-1:0];
					end
				end
			end
			vpz_pkg::CMD_RESIZE: begin
				view_w_d = new_w_s1;
				view_h_d = new_h_s1;
			end
			default: ;
		endcase
	end

	// The state only moves on a beat that also loads the result, so a
	// pending result stays stable until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_vel_x_q  <= '0;
			key_vel_y_q  <= '0;
			edge_vel_x_q <= '0;
			edge_vel_y_q <= '0;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			zoom_q       <= '0;
			view_w_q     <= '0;
			view_h_q     <= '0;
			changed_q    <= 1'b1;
		end else if (advance) begin
			key_vel_x_q  <= key_vel_x_d;
			key_vel_y_q  <= key_vel_y_d;
			edge_vel_x_q <= edge_vel_x_d;
			edge_vel_y_q <= edge_vel_y_d;
			pos_x_q      <= pos_x_d;
			pos_y_q      <= pos_y_d;
			zoom_q       <= zoom_d;
			view_w_q     <= view_w_d;
			view_h_q     <= view_h_d;
			changed_q    <= changed_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, changed_q, zoom_q, pos_y_q, pos_x_q};

endmodule
